// ===== hw/rtl/sndaw_pkg.sv =====
`timescale 1ns / 1ps

package sndaw_pkg;

    // Number of axes actually walked; axes at or above this count act as size 1, stride 0.
    localparam int MAX_AXES = 3;

    // Hardware always carries three axis slots: 0 inner, 1 middle, 2 outer.
    localparam int AXIS_SLOTS = 3;

    localparam int SIZE_W    = 13;
    localparam int CNT_W     = 12;
    localparam int STRIDE_W  = 24;
    localparam int OFFSET_W  = 31;
    localparam int PROD_W    = CNT_W + STRIDE_W;
    localparam int STRIDED_W = 48;
    localparam int DENSE_W   = 37;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 31;

    localparam logic [SIZE_W-1:0] SIZE_CAP = 13'd4096;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 88;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIZE_OUTER     = 3'd0,
        REG_SIZE_MIDDLE    = 3'd1,
        REG_SIZE_INNER     = 3'd2,
        REG_STRIDE_OUTER   = 3'd3,
        REG_STRIDE_MIDDLE  = 3'd4,
        REG_STRIDE_INNER   = 3'd5,
        REG_STRIDED_OFFSET = 3'd6,
        REG_DENSE_OFFSET   = 3'd7
    } cfg_reg_t;

    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [SIZE_W-1:0] size_t_t;

endpackage

// ===== hw/rtl/strided_nd_address_walker_core.sv =====
`timescale 1ns / 1ps

// Strided N-d address walker. Each input beat either restarts the walk
// (s_tdata[0] = 1) or advances it by one element; a beat that yields an element
// produces one output beat with the strided element index, the dense element
// index and tlast on the final element. The walker takes one input beat per
// cycle unless backpressure stalls it: the axis counters update in the cycle
// a beat is accepted, and the address math follows in a three-stage pipeline
// (counter snapshot, three 12x24 stride products plus the dense offset sum,
// final sum with the strided offset). Each stage has its own valid bit, so
// backpressure only stalls as far as the first empty stage. Restarts with any
// used size of zero, advances with no walk active and advances that carry out
// of the outermost axis are consumed without an output beat. Registers are
// written through the cfg port and are read live, so rewrite them only while
// the pipeline is empty. No clearing pass after reset.
module strided_nd_address_walker_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_wr_en,
    input  logic [sndaw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sndaw_pkg::CFG_W-1:0]           cfg_data,

    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [sndaw_pkg::IN_TDATA_W-1:0]      s_tdata,   // [0] restart, rest zero

    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [sndaw_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [47:0] strided_index,
                                                             // [84:48] dense_index, rest zero
    output logic                                  m_tlast    // last element of the walk
);

    localparam int SLOTS = sndaw_pkg::AXIS_SLOTS;

    // ---------------- configuration registers ----------------
    logic [sndaw_pkg::SIZE_W-1:0]   size_reg   [SLOTS];   // 0 inner, 1 middle, 2 outer
    logic [sndaw_pkg::STRIDE_W-1:0] stride_reg [SLOTS];
    logic [sndaw_pkg::OFFSET_W-1:0] strided_offset_reg;
    logic [sndaw_pkg::OFFSET_W-1:0] dense_offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg[0]        <= 13'd1;
            size_reg[1]        <= 13'd1;
            size_reg[2]        <= 13'd1;
            stride_reg[0]      <= 24'd1;
            stride_reg[1]      <= 24'd0;
            stride_reg[2]      <= 24'd0;
            strided_offset_reg <= '0;
            dense_offset_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (sndaw_pkg::cfg_reg_t'(cfg_index))
                sndaw_pkg::REG_SIZE_OUTER:     size_reg[2]   <= cfg_data[sndaw_pkg::SIZE_W-1:0];
                sndaw_pkg::REG_SIZE_MIDDLE:    size_reg[1]   <= cfg_data[sndaw_pkg::SIZE_W-1:0];
                sndaw_pkg::REG_SIZE_INNER:     size_reg[0]   <= cfg_data[sndaw_pkg::SIZE_W-1:0];
                sndaw_pkg::REG_STRIDE_OUTER:   stride_reg[2] <= cfg_data[sndaw_pkg::STRIDE_W-1:0];
                sndaw_pkg::REG_STRIDE_MIDDLE:  stride_reg[1] <= cfg_data[sndaw_pkg::STRIDE_W-1:0];
                sndaw_pkg::REG_STRIDE_INNER:   stride_reg[0] <= cfg_data[sndaw_pkg::STRIDE_W-1:0];
                sndaw_pkg::REG_STRIDED_OFFSET: strided_offset_reg <= cfg_data;
                sndaw_pkg::REG_DENSE_OFFSET:   dense_offset_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective size and stride per slot: capped at 4096, unused slots act as 1 / 0.
    logic [sndaw_pkg::SIZE_W-1:0]   eff_size   [SLOTS];
    logic [sndaw_pkg::STRIDE_W-1:0] eff_stride [SLOTS];

    always_comb
    begin
        for (int a = 0; a < SLOTS; a++)
        begin
            if (a >= sndaw_pkg::MAX_AXES)
            begin
                eff_size[a]   = 13'd1;
                eff_stride[a] = '0;
            end
            else
            begin
                eff_size[a]   = (size_reg[a] > sndaw_pkg::SIZE_CAP) ? sndaw_pkg::SIZE_CAP
                                                                    : size_reg[a];
                eff_stride[a] = stride_reg[a];
            end
        end
    end

    // ---------------- walk state ----------------
    sndaw_pkg::cnt_t               cnt_reg  [SLOTS];
    sndaw_pkg::cnt_t               cnt_next [SLOTS];
    logic [sndaw_pkg::DENSE_W-1:0] dense_run_reg, dense_run_next;
    logic                          done_reg, done_next;
    logic                          emit;      // accepted beat yields an element
    logic                          last_flag;

    // pipeline handshake
    logic v1_reg, v2_reg, v3_reg;
    logic load1, load2, load3;
    logic accept;

    assign load3    = !v3_reg || m_tready;
    assign load2    = !v2_reg || load3;
    assign load1    = !v1_reg || load2;
    assign s_tready = load1;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        logic any_zero;
        logic carry;
        logic all_top;

        any_zero = 1'b0;
        carry    = 1'b1;
        all_top  = 1'b1;

        for (int a = 0; a < SLOTS; a++)
        begin
            cnt_next[a] = cnt_reg[a];
            if (eff_size[a] == '0)
                any_zero = 1'b1;
        end
        dense_run_next = dense_run_reg;
        done_next      = done_reg;
        emit           = 1'b0;

        if (s_tdata[0])
        begin
            if (any_zero)
                done_next = 1'b1;
            else
            begin
                for (int a = 0; a < SLOTS; a++)
                    cnt_next[a] = '0;
                dense_run_next = '0;
                done_next      = 1'b0;
                emit           = 1'b1;
            end
        end
        else if (!done_reg)
        begin
            // innermost counts fastest; a counter at or past its top wraps and carries
            for (int a = 0; a < SLOTS; a++)
            begin
                if (carry)
                begin
                    if (({1'b0, cnt_reg[a]} + 13'd1) < eff_size[a])
                    begin
                        cnt_next[a] = cnt_reg[a] + 12'd1;
                        carry       = 1'b0;
                    end
                    else
                        cnt_next[a] = '0;
                end
            end
            if (carry)
                done_next = 1'b1;
            else
            begin
                dense_run_next = dense_run_reg + 37'd1;
                emit           = 1'b1;
            end
        end

        for (int a = 0; a < SLOTS; a++)
        begin
            if (({1'b0, cnt_next[a]} + 13'd1) < eff_size[a])
                all_top = 1'b0;
        end
        last_flag = all_top;
        if (emit && all_top)
            done_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < SLOTS; a++)
                cnt_reg[a] <= '0;
            dense_run_reg <= '0;
            done_reg      <= 1'b1;
        end
        else if (accept)
        begin
            for (int a = 0; a < SLOTS; a++)
                cnt_reg[a] <= cnt_next[a];
            dense_run_reg <= dense_run_next;
            done_reg      <= done_next;
        end
    end

    // ---------------- stage 1: counter snapshot ----------------
    sndaw_pkg::cnt_t               cnt1_reg [SLOTS];
    logic [sndaw_pkg::DENSE_W-1:0] dense1_reg;
    logic                          last1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (load1)
            v1_reg <= accept && emit;
    end

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            for (int a = 0; a < SLOTS; a++)
                cnt1_reg[a] <= cnt_next[a];
            dense1_reg <= dense_run_next;
            last1_reg  <= last_flag;
        end
    end

    // ---------------- stage 2: per-axis products ----------------
    logic [sndaw_pkg::PROD_W-1:0]  prod2_reg [SLOTS];
    logic [sndaw_pkg::DENSE_W-1:0] dense2_reg;
    logic                          last2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (load2)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            for (int a = 0; a < SLOTS; a++)
                prod2_reg[a] <= sndaw_pkg::PROD_W'(cnt1_reg[a]) *
                                sndaw_pkg::PROD_W'(eff_stride[a]);
            // dense index wraps at 37 bits
            dense2_reg <= dense1_reg + sndaw_pkg::DENSE_W'(dense_offset_reg);
            last2_reg  <= last1_reg;
        end
    end

    // ---------------- stage 3: output register ----------------
    logic [sndaw_pkg::STRIDED_W-1:0] strided3_reg;
    logic [sndaw_pkg::DENSE_W-1:0]   dense3_reg;
    logic                            last3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (load3)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load3)
        begin
            // sum stays well below 2^48, no wrap possible
            strided3_reg <= sndaw_pkg::STRIDED_W'(prod2_reg[0]) +
                            sndaw_pkg::STRIDED_W'(prod2_reg[1]) +
                            sndaw_pkg::STRIDED_W'(prod2_reg[2]) +
                            sndaw_pkg::STRIDED_W'(strided_offset_reg);
            dense3_reg   <= dense2_reg;
            last3_reg    <= last2_reg;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {3'b000, dense3_reg, strided3_reg};
    assign m_tlast  = last3_reg;

endmodule
